// ===== rtl/integer_radix_formatter_defines.svh =====
// Assertion macros used by integer_radix_formatter.sv.
`ifndef INTEGER_RADIX_FORMATTER_DEFINES_SVH
`define INTEGER_RADIX_FORMATTER_DEFINES_SVH

`ifndef SYNTH
`define IRF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define IRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define IRF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define IRF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/irf_pkg.sv =====
`default_nettype none

package irf_pkg;

    localparam int DIGIT_SLOTS_DEF = 32;
    localparam int MAX_DIGITS      = 32;

    localparam logic [2:0] CONV_BIN    = 3'd0;
    localparam logic [2:0] CONV_SDEC   = 3'd1;
    localparam logic [2:0] CONV_UDEC   = 3'd2;
    localparam logic [2:0] CONV_OCT    = 3'd3;
    localparam logic [2:0] CONV_HEX_LO = 3'd4;
    localparam logic [2:0] CONV_HEX_UP = 3'd5;

    localparam logic [7:0] ASC_ZERO  = 8'h30;
    localparam logic [7:0] ASC_SPACE = 8'h20;
    localparam logic [7:0] ASC_MINUS = 8'h2D;
    localparam logic [7:0] ASC_LO_A  = 8'h61;
    localparam logic [7:0] ASC_UP_A  = 8'h41;

    localparam logic [31:0] SIGN_MASK   = 32'h8000_0000;
    localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        base = upper ? ASC_UP_A : ASC_LO_A;
        if (d > 4'd9) begin
            digit_char = {4'd0, d} - 8'd10 + base;
        end else begin
            digit_char = {4'd0, d} + ASC_ZERO;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/integer_radix_formatter.sv =====
// integer_radix_formatter: one integer conversion request in, its ASCII text out.
// Input channel: i_valid / o_stall with i_value, i_conversion, i_min_width and
// i_zero_pad. Output channel: o_valid / i_stall with o_character and o_last,
// one character per transfer, most significant first, o_last on the final one.
// A request is taken only while the block is idle; o_stall is high meanwhile.
// Conversion runs first, one digit per cycle for binary, octal and hex; each
// decimal digit takes a reciprocal multiply and then a remainder step, with the
// digits kept in a small RAM. Output then runs through the sign state, the pad
// state and, per digit, a RAM read and then the output register.
// Kinds 6 and 7 yield no characters.
// A stall on the output holds the output register and the output sequencer.
// Synchronous active-low reset returns to idle and drops any pending output.
`default_nettype none

`include "integer_radix_formatter_defines.svh"

module integer_radix_formatter #(
    parameter int DIGIT_SLOTS = irf_pkg::DIGIT_SLOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_value,
    input  wire logic [2:0]  i_conversion,
    input  wire logic [5:0]  i_min_width,
    input  wire logic        i_zero_pad,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic      [7:0]  o_character,
    output logic             o_last
);

    localparam int AW = $clog2(DIGIT_SLOTS);
    localparam int CW = $clog2(DIGIT_SLOTS + 1);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CONV  = 7'b0000010,
        ST_DIV   = 7'b0000100,
        ST_SIGN  = 7'b0001000,
        ST_PAD   = 7'b0010000,
        ST_READ  = 7'b0100000,
        ST_DIGIT = 7'b1000000
    } t_state;

    t_state        r_state, n_state;
    logic          r_out_valid, n_out_valid;
    logic [CW-1:0] r_nd, n_nd;
    logic [CW-1:0] r_pad, n_pad;

    logic [31:0]   r_num, n_num;
    logic [63:0]   r_prod, n_prod;
    logic [CW-1:0] r_width, n_width;
    logic          r_neg, n_neg;
    logic          r_dec, n_dec;
    logic [2:0]    r_sh, n_sh;
    logic [3:0]    r_mask, n_mask;
    logic          r_upper, n_upper;
    logic [7:0]    r_padch, n_padch;
    logic [7:0]    r_char, n_char;
    logic          r_last, n_last;

    logic          accept;
    logic          slot_free;
    logic          ram_we;
    logic [3:0]    ram_wdata;
    logic [3:0]    ram_rdata;
    logic [CW-1:0] nd_inc;
    logic [CW-1:0] wsat;
    logic [31:0]   quot;
    logic [31:0]   quot_x10;
    logic [31:0]   rem;
    logic          conv_done;
    logic          bad_kind;
    logic          last_fire;

    assign accept    = i_valid && !o_stall;
    assign slot_free = !r_out_valid || !i_stall;
    assign nd_inc    = r_nd + CW'(1);
    assign quot      = 32'(r_prod[63:irf_pkg::RECIP_SHIFT]);
    assign quot_x10  = (quot << 3) + (quot << 1);
    assign rem       = r_num - quot_x10;
    assign wsat      = (CW'(i_min_width) > CW'(DIGIT_SLOTS)) ? CW'(DIGIT_SLOTS)
                                                             : CW'(i_min_width);
    assign bad_kind  = accept && (i_conversion > irf_pkg::CONV_HEX_UP);
    assign last_fire = (r_state == ST_DIGIT) && slot_free && (r_nd == CW'(1));

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_stall;
        n_nd        = r_nd;
        n_pad       = r_pad;
        n_num       = r_num;
        n_prod      = r_prod;
        n_width     = r_width;
        n_neg       = r_neg;
        n_dec       = r_dec;
        n_sh        = r_sh;
        n_mask      = r_mask;
        n_upper     = r_upper;
        n_padch     = r_padch;
        n_char      = r_char;
        n_last      = r_last;
        ram_we      = 1'b0;
        ram_wdata   = 4'd0;
        conv_done   = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_nd    = '0;
                    n_width = wsat;
                    n_padch = i_zero_pad ? irf_pkg::ASC_ZERO : irf_pkg::ASC_SPACE;
                    n_neg   = 1'b0;
                    n_dec   = 1'b0;
                    n_upper = 1'b0;
                    n_sh    = 3'd4;
                    n_mask  = 4'hF;
                    n_num   = i_value;
                    n_state = ST_CONV;
                    unique case (i_conversion)
                        irf_pkg::CONV_BIN: begin
                            n_sh   = 3'd1;
                            n_mask = 4'h1;
                        end
                        irf_pkg::CONV_SDEC: begin
                            n_dec = 1'b1;
                            n_neg = (i_value & irf_pkg::SIGN_MASK) != 32'd0;
                            if ((i_value & irf_pkg::SIGN_MASK) != 32'd0) begin
                                n_num = ~i_value + 32'd1;
                            end
                        end
                        irf_pkg::CONV_UDEC: begin
                            n_dec = 1'b1;
                        end
                        irf_pkg::CONV_OCT: begin
                            n_sh   = 3'd3;
                            n_mask = 4'h7;
                        end
                        irf_pkg::CONV_HEX_LO: begin
                        end
                        irf_pkg::CONV_HEX_UP: begin
                            n_upper = 1'b1;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CONV: begin
                if (r_dec) begin
                    n_prod  = {32'd0, r_num} * {32'd0, irf_pkg::RECIP_TEN};
                    n_state = ST_DIV;
                end else begin
                    ram_we    = 1'b1;
                    ram_wdata = r_num[3:0] & r_mask;
                    n_num     = r_num >> r_sh;
                    n_nd      = nd_inc;
                    conv_done = (n_num == 32'd0);
                end
            end
            ST_DIV: begin
                ram_we    = 1'b1;
                ram_wdata = rem[3:0];
                n_num     = quot;
                n_nd      = nd_inc;
                conv_done = (quot == 32'd0);
                n_state   = ST_CONV;
            end
            ST_SIGN: begin
                if (!r_neg) begin
                    n_state = (r_pad != '0) ? ST_PAD : ST_READ;
                end else if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_char      = irf_pkg::ASC_MINUS;
                    n_last      = 1'b0;
                    n_state     = (r_pad != '0) ? ST_PAD : ST_READ;
                end
            end
            ST_PAD: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_char      = r_padch;
                    n_last      = 1'b0;
                    n_pad       = r_pad - CW'(1);
                    if (r_pad == CW'(1)) begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_DIGIT;
            end
            ST_DIGIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_char      = irf_pkg::digit_char(ram_rdata, r_upper);
                    n_last      = (r_nd == CW'(1));
                    n_nd        = r_nd - CW'(1);
                    n_state     = (r_nd == CW'(1)) ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (conv_done) begin
            n_pad   = (r_width > nd_inc) ? r_width - nd_inc : '0;
            n_state = ST_SIGN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_nd        <= '0;
            r_pad       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_nd        <= n_nd;
            r_pad       <= n_pad;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num   <= n_num;
        r_prod  <= n_prod;
        r_width <= n_width;
        r_neg   <= n_neg;
        r_dec   <= n_dec;
        r_sh    <= n_sh;
        r_mask  <= n_mask;
        r_upper <= n_upper;
        r_padch <= n_padch;
        r_char  <= n_char;
        r_last  <= n_last;
    end

    irf_ram #(
        .WIDTH (4),
        .DEPTH (DIGIT_SLOTS)
    ) u_digits (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_nd[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (AW'(r_nd - CW'(1))),
        .o_rdata (ram_rdata)
    );

    assign o_stall     = (r_state != ST_IDLE);
    assign o_valid     = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

    `IRF_ASSERT_IMP(a_nd_bound, i_clk, i_rst_n, 1'b1, r_nd <= CW'(irf_pkg::MAX_DIGITS))
    `IRF_ASSERT_IMP(a_pad_nonzero, i_clk, i_rst_n, r_state == ST_PAD, r_pad != '0)
    `IRF_ASSERT_NEXT(a_bad_kind_idle, i_clk, i_rst_n, bad_kind, r_state == ST_IDLE)
    `IRF_ASSERT_NEXT(a_last_digit, i_clk, i_rst_n, last_fire, o_valid && o_last && !o_stall)

endmodule

`default_nettype wire

// ===== rtl/irf_ram.sv =====
`default_nettype none

module irf_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== tb/integer_radix_formatter_test.sv =====
`timescale 1ns / 100ps

module integer_radix_formatter_test;

    localparam int TEXT_BYTES   = 40;
    localparam int TEXT_W       = 8 * TEXT_BYTES;
    localparam int RANDOM_ITEMS = 306;
    localparam int QUIET_TAIL   = 60;
    localparam int DRAIN_CYCLES = 200;
    localparam int STUCK_LIMIT  = 4000;
    localparam int SHOWN_ERRORS = 10;

    localparam logic [2:0] CONV_NONE_6 = 3'd6;
    localparam logic [2:0] CONV_NONE_7 = 3'd7;

    typedef struct packed {
        logic [31:0]       value;
        logic [2:0]        conv;
        logic [5:0]        width;
        logic              zpad;
        logic              typed;
        logic [TEXT_W-1:0] text;
    } t_request;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_char;

    localparam int DIR_ROWS = 24;
    localparam t_request DIRECTED [0:DIR_ROWS-1] = '{
        '{32'h0000_0000, irf_pkg::CONV_UDEC,   6'd0,  1'b0, 1'b1, "0"},
        '{32'h0000_0000, irf_pkg::CONV_BIN,    6'd0,  1'b0, 1'b1, "0"},
        '{32'h8000_0000, irf_pkg::CONV_SDEC,   6'd0,  1'b0, 1'b1, "-2147483648"},
        '{32'hFFFF_FFFF, irf_pkg::CONV_SDEC,   6'd0,  1'b0, 1'b1, "-1"},
        '{32'h7FFF_FFFF, irf_pkg::CONV_SDEC,   6'd0,  1'b0, 1'b1, "2147483647"},
        '{32'hFFFF_FFFF, irf_pkg::CONV_UDEC,   6'd0,  1'b0, 1'b1, "4294967295"},
        '{32'hFFFF_FFFF, irf_pkg::CONV_BIN,    6'd0,  1'b0, 1'b1,
          {"11111111", "11111111", "11111111", "11111111"}},
        '{32'hFFFF_FFFF, irf_pkg::CONV_OCT,    6'd0,  1'b0, 1'b1, {"3", "7777777777"}},
        '{32'hFFFF_FFFF, irf_pkg::CONV_HEX_LO, 6'd0,  1'b0, 1'b1, "ffffffff"},
        '{32'hFFFF_FFFF, irf_pkg::CONV_HEX_UP, 6'd0,  1'b0, 1'b1, "FFFFFFFF"},
        '{32'hDEAD_BEEF, irf_pkg::CONV_HEX_LO, 6'd0,  1'b0, 1'b0, ""},
        '{32'h0000_ABCD, irf_pkg::CONV_HEX_UP, 6'd8,  1'b1, 1'b1, "0000ABCD"},
        '{32'h0000_0005, irf_pkg::CONV_UDEC,   6'd4,  1'b0, 1'b1, "   5"},
        '{32'hFFFF_FFFB, irf_pkg::CONV_SDEC,   6'd4,  1'b1, 1'b1, "-0005"},
        '{32'hFFFF_FFFB, irf_pkg::CONV_SDEC,   6'd4,  1'b0, 1'b1, "-   5"},
        '{32'h0001_E240, irf_pkg::CONV_UDEC,   6'd3,  1'b1, 1'b0, ""},
        '{32'h0000_0001, irf_pkg::CONV_BIN,    6'd63, 1'b1, 1'b0, ""},
        '{32'h8000_0000, irf_pkg::CONV_SDEC,   6'd40, 1'b0, 1'b0, ""},
        '{32'h1234_5678, CONV_NONE_6,          6'd5,  1'b1, 1'b1, ""},
        '{32'hFFFF_FFFF, CONV_NONE_7,          6'd63, 1'b0, 1'b1, ""},
        '{32'h1234_5678, irf_pkg::CONV_OCT,    6'd32, 1'b0, 1'b0, ""},
        '{32'hAAAA_AAAA, irf_pkg::CONV_BIN,    6'd33, 1'b1, 1'b0, ""},
        '{32'h0000_0007, irf_pkg::CONV_HEX_LO, 6'd1,  1'b1, 1'b0, ""},
        '{32'h0000_0000, irf_pkg::CONV_SDEC,   6'd32, 1'b0, 1'b0, ""}
    };

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic [31:0] i_value      = '0;
    logic [2:0]  i_conversion = irf_pkg::CONV_BIN;
    logic [5:0]  i_min_width  = '0;
    logic        i_zero_pad   = 1'b0;
    logic        i_stall      = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [7:0]  o_character;
    logic        o_last;

    t_char pending_text [$];
    int    text_errors  = 0;
    int    stuck_cycles = 0;
    int    stall_left   = 0;
    bit    idle_on      = 1'b1;

    integer_radix_formatter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_value      (i_value),
        .i_conversion (i_conversion),
        .i_min_width  (i_min_width),
        .i_zero_pad   (i_zero_pad),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_character  (o_character),
        .o_last       (o_last)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [TEXT_W-1:0] format_number(input t_request r);
        logic [TEXT_W-1:0] t;
        logic [31:0]       mag;
        logic [31:0]       radix;
        logic [7:0]        digs [0:irf_pkg::MAX_DIGITS-1];
        logic [7:0]        pad_ch;
        logic [7:0]        alpha;
        logic [3:0]        d;
        logic              upper;
        int                nd;
        int                field;
        int                i;
        t      = '0;
        mag    = r.value;
        nd     = 0;
        radix  = 32'd2;
        field  = (r.width > 6'd32) ? 32 : int'(r.width);
        pad_ch = r.zpad ? irf_pkg::ASC_ZERO : irf_pkg::ASC_SPACE;
        upper  = (r.conv == irf_pkg::CONV_HEX_UP);
        alpha  = upper ? irf_pkg::ASC_UP_A : irf_pkg::ASC_LO_A;
        case (r.conv)
            irf_pkg::CONV_BIN: begin
                radix = 32'd2;
            end
            irf_pkg::CONV_SDEC, irf_pkg::CONV_UDEC: begin
                radix = 32'd10;
            end
            irf_pkg::CONV_OCT: begin
                radix = 32'd8;
            end
            irf_pkg::CONV_HEX_LO, irf_pkg::CONV_HEX_UP: begin
                radix = 32'd16;
            end
            default: begin
                return '0;
            end
        endcase
        if (r.conv == irf_pkg::CONV_SDEC && (mag & irf_pkg::SIGN_MASK) != 0) begin
            mag = -mag;
            t = {t[TEXT_W-9:0], irf_pkg::ASC_MINUS};
        end
        do begin
            d = 4'(mag % radix);
            digs[nd] = (d > 4'd9) ? {4'd0, d} - 8'd10 + alpha
                                  : {4'd0, d} + irf_pkg::ASC_ZERO;
            nd++;
            mag = mag / radix;
        end while (mag != 0);
        for (i = nd; i < field; i++) begin
            t = {t[TEXT_W-9:0], pad_ch};
        end
        for (i = nd - 1; i >= 0; i--) begin
            t = {t[TEXT_W-9:0], digs[i]};
        end
        return t;
    endfunction

    task automatic drive_request(input t_request r);
        logic [TEXT_W-1:0] text;
        logic [7:0]        b;
        int                i;
        int                last_idx;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_value      <= r.value;
        i_conversion <= r.conv;
        i_min_width  <= r.width;
        i_zero_pad   <= r.zpad;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        text = r.typed ? r.text : format_number(r);
        last_idx = -1;
        for (i = 0; i < TEXT_BYTES; i++) begin
            if (text[i*8 +: 8] != 8'h00 && last_idx < 0) last_idx = i;
        end
        for (i = TEXT_BYTES - 1; i >= 0; i--) begin
            b = text[i*8 +: 8];
            if (b != 8'h00) pending_text.push_back('{b, i == last_idx});
        end
        @(negedge i_clk);
    endtask

    // Hold stall in random bursts while idling is enabled.
    always @(negedge i_clk) begin
        if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 8);
        i_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
    end

    always @(posedge i_clk) begin
        t_char want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_text.size() == 0) begin
                if (text_errors < SHOWN_ERRORS)
                    $display("unexpected character %h last %b", o_character, o_last);
                text_errors++;
            end else begin
                want = pending_text.pop_front();
                if (o_character !== want.ch || o_last !== want.last) begin
                    if (text_errors < SHOWN_ERRORS)
                        $display("character mismatch: expected %h last %b, got %h last %b",
                                 want.ch, want.last, o_character, o_last);
                    text_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        t_request r;
        int       k;
        int       sent;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        for (k = 0; k < DIR_ROWS; k++) begin
            drive_request(DIRECTED[k]);
        end
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            idle_on = (sent < RANDOM_ITEMS - QUIET_TAIL) && ((sent % 80) < 60);
            r.typed = 1'b0;
            r.text  = '0;
            case ($urandom_range(0, 5))
                0: r.value = $urandom_range(0, 20);
                1: r.value = $urandom >> $urandom_range(0, 31);
                2: r.value = -32'($urandom_range(1, 1000));
                3: begin
                    case ($urandom_range(0, 3))
                        0: r.value = 32'h0000_0000;
                        1: r.value = 32'h8000_0000;
                        2: r.value = 32'h7FFF_FFFF;
                        default: r.value = 32'hFFFF_FFFF;
                    endcase
                end
                default: r.value = $urandom;
            endcase
            r.conv  = ($urandom_range(0, 19) == 0)
                      ? 3'($urandom_range(CONV_NONE_6, CONV_NONE_7))
                      : 3'($urandom_range(irf_pkg::CONV_BIN, irf_pkg::CONV_HEX_UP));
            r.width = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                  : 6'($urandom_range(0, 12));
            r.zpad  = 1'($urandom_range(0, 1));
            drive_request(r);
            sent++;
        end
        i_valid <= 1'b0;
        while (pending_text.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (text_errors == 0 && pending_text.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
